/* rtl/core/aust_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle unwrap and speed tracker package
// Shared widths, codes, reset values and controller/datapath interface types.
// ----------------------------------------------------------------------------
package aust_pkg;

  localparam int TURN_COUNT_BITS_DEF = 32;
  localparam int SPEED_FRAC_BITS_DEF = 16;

  localparam int TURN_UNITS  = 5760;
  localparam int HALF_TURN   = 2880;
  localparam int SPEED_SCALE = 1000;

  localparam int ANGLE_W = 13;
  localparam int MAGN_W  = 8;
  localparam int TIME_W  = 32;
  localparam int D_W     = ANGLE_W + 1;
  localparam int NUM_W   = 22;
  localparam int ACC_W   = 48;
  localparam int HALF_W  = ACC_W / 2;
  localparam int ALPHA_W = 16;
  localparam int PROD_W  = HALF_W + ALPHA_W;
  localparam int P_W     = ACC_W + ALPHA_W;
  localparam int TOT_W   = 45;
  localparam int OUT32_W = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 168;

  localparam logic [7:0]  POLL_PERIOD_RST    = 8'd5;
  localparam logic [15:0] PROBE_INTERVAL_RST = 16'd1000;
  localparam logic [7:0]  ERROR_LIMIT_RST    = 8'd3;
  localparam logic [15:0] SPEED_ALPHA_RST    = 16'd6554;

  typedef enum logic [1:0] {
    ACT_POLL  = 2'd0,
    ACT_SEED  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLL_PERIOD    = 2'd0,
    CFG_PROBE_INTERVAL = 2'd1,
    CFG_ERROR_LIMIT    = 2'd2,
    CFG_SPEED_ALPHA    = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCALE,
    ST_DIV,
    ST_INST,
    ST_DIFF,
    ST_ABS,
    ST_MLO,
    ST_MHI,
    ST_SUM,
    ST_ACC,
    ST_TOTAL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic eval;
    logic scale;
    logic div_step;
    logic inst;
    logic diff;
    logic absd;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic acc;
    logic total;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic speed_path;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

/* rtl/core/aust_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider, one quotient bit per step, quotient shifts into
// the dividend register.
// ----------------------------------------------------------------------------
module aust_div #(
  parameter int DVD_W = 38,
  parameter int DVS_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             step_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic [DVD_W-1:0] quotient_o,
  output logic             last_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor_i};
  assign ge      = rem_sh >= {1'b0, divisor_i};

  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (start_i) begin
      dvd_d = dividend_i;
      rem_d = '0;
      cnt_d = CNT_W'(DVD_W);
    end else if (step_i) begin
      dvd_d = {dvd_q[DVD_W-2:0], ge};
      rem_d = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign quotient_o = dvd_q;
  assign last_o     = cnt_q == CNT_W'(1);

endmodule

/* rtl/core/aust_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle unwrap and speed tracker controller
// Sequences one request through evaluation, division and filtering (speed path only) and output.
// ----------------------------------------------------------------------------
module aust_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  aust_pkg::status_t status_i,
  output aust_pkg::cmd_t    cmd_o
);

  import aust_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_EVAL;
      ST_EVAL:  state_d = status_i.speed_path ? ST_SCALE : ST_TOTAL;
      ST_SCALE: state_d = ST_DIV;
      ST_DIV:   if (status_i.div_last) state_d = ST_INST;
      ST_INST:  state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_ABS;
      ST_ABS:   state_d = ST_MLO;
      ST_MLO:   state_d = ST_MHI;
      ST_MHI:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_ACC;
      ST_ACC:   state_d = ST_OUT;
      ST_TOTAL: state_d = ST_OUT;
      ST_OUT:   if (status_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EVAL:  cmd_o.eval     = 1'b1;
      ST_SCALE: cmd_o.scale    = 1'b1;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_INST:  cmd_o.inst     = 1'b1;
      ST_DIFF:  cmd_o.diff     = 1'b1;
      ST_ABS:   cmd_o.absd     = 1'b1;
      ST_MLO: begin
        cmd_o.mul_lo = 1'b1;
        cmd_o.total  = 1'b1;
      end
      ST_MHI:   cmd_o.mul_hi   = 1'b1;
      ST_SUM:   cmd_o.sum      = 1'b1;
      ST_ACC:   cmd_o.acc      = 1'b1;
      ST_TOTAL: cmd_o.total    = 1'b1;
      ST_OUT:   cmd_o.out_load = status_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/aust_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle unwrap and speed tracker datapath
// Configuration, tracking state, speed filter arithmetic and result register.
// ----------------------------------------------------------------------------
module aust_dpath #(
  parameter int TURN_COUNT_BITS = aust_pkg::TURN_COUNT_BITS_DEF,
  parameter int SPEED_FRAC_BITS = aust_pkg::SPEED_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [aust_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [aust_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [aust_pkg::IN_TDATA_W-1:0]  in_tdata_i,
  input  logic [aust_pkg::IN_TUSER_W-1:0]  in_tuser_i,
  input  aust_pkg::cmd_t                   cmd_i,
  output aust_pkg::status_t                status_o,
  output logic                             out_tvalid_o,
  input  logic                             out_tready_i,
  output logic [aust_pkg::OUT_TDATA_W-1:0] out_tdata_o
);

  import aust_pkg::*;

  localparam int TCB   = TURN_COUNT_BITS;
  localparam int DVD_W = NUM_W + SPEED_FRAC_BITS;

  localparam logic signed [D_W-1:0] TurnS    = D_W'(TURN_UNITS);
  localparam logic signed [D_W-1:0] HalfS    = D_W'(HALF_TURN);
  localparam logic signed [D_W-1:0] NegHalfS = D_W'(-HALF_TURN);

  localparam logic signed [ACC_W+1:0] AccMax = {3'b000, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W+1:0] AccMin = {3'b111, {(ACC_W-1){1'b0}}};

  // configuration
  logic [7:0]         poll_period_q;
  logic [15:0]        probe_int_q;
  logic [7:0]         err_limit_q;
  logic [ALPHA_W-1:0] alpha_q;

  // latched request
  logic [1:0]         act_q;
  logic [TIME_W-1:0]  now_q;
  logic               ok_q;
  logic [ANGLE_W-1:0] ang_q;
  logic [MAGN_W-1:0]  magin_q;

  // tracking state
  logic                    healthy_q, healthy_d;
  logic [ANGLE_W-1:0]      last_angle_q, last_angle_d;
  logic [TCB-1:0]          turns_q, turns_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [MAGN_W-1:0]       mag_q, mag_d;
  logic [31:0]             err_cnt_q, err_cnt_d;
  logic [7:0]              cons_q, cons_d;
  logic [TIME_W-1:0]       last_sample_q, last_sample_d;
  logic [TIME_W-1:0]       last_probe_q, last_probe_d;
  logic                    probe_q, probe_d;
  logic                    taken_q, taken_d;

  // speed work registers
  logic signed [D_W-1:0]   dadj_q, dadj_d;
  logic [TIME_W-1:0]       dt_q, dt_d;
  logic signed [ACC_W-1:0] inst_q;
  logic signed [ACC_W:0]   diff_q;
  logic [ACC_W-1:0]        absd_q;
  logic                    dneg_q;
  logic [PROD_W-1:0]       plo_q, phi_q;
  logic [P_W-1:0]          p_q;
  logic [TOT_W-1:0]        total_q;

  logic                    out_valid_q;
  logic [OUT_TDATA_W-1:0]  out_data_q;

  // combinational terms
  logic [TIME_W-1:0]       dt_w, since_probe_w;
  logic                    speed_w;
  logic signed [D_W-1:0]   draw_w, dadj_w;
  logic [7:0]              cons_inc_w;
  logic [D_W-1:0]          dabs_w;
  logic [NUM_W-1:0]        num_w;
  logic [DVD_W-1:0]        quot_w;
  logic                    div_last_w;
  logic [ACC_W-1:0]        q_ext_w;
  logic signed [ACC_W:0]   neg_diff_w;
  logic [HALF_W-1:0]       mul_a_w;
  logic [PROD_W-1:0]       prod_w;
  logic signed [ACC_W+1:0] acc_ext_w, step_ext_w, acc_sum_w;
  logic [TOT_W-1:0]        turns45_w, total_w;
  logic [OUT32_W-1:0]      turn32_w;
  logic signed [ACC_W-1:0] acc_sh_w;
  logic [OUT32_W-1:0]      spd_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_period_q <= POLL_PERIOD_RST;
      probe_int_q   <= PROBE_INTERVAL_RST;
      err_limit_q   <= ERROR_LIMIT_RST;
      alpha_q       <= SPEED_ALPHA_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_POLL_PERIOD:    poll_period_q <= cfg_data_i[7:0];
        CFG_PROBE_INTERVAL: probe_int_q   <= cfg_data_i;
        CFG_ERROR_LIMIT:    err_limit_q   <= cfg_data_i[7:0];
        CFG_SPEED_ALPHA:    alpha_q       <= cfg_data_i;
        default:            poll_period_q <= poll_period_q;
      endcase
    end
  end

  // request fields: now_ms, read_ok, angle_raw, field_magnitude
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= in_tuser_i;
      now_q   <= in_tdata_i[31:0];
      ok_q    <= in_tdata_i[32];
      ang_q   <= in_tdata_i[45:33];
      magin_q <= in_tdata_i[53:46];
    end
  end

  assign dt_w          = now_q - last_sample_q;
  assign since_probe_w = now_q - last_probe_q;
  assign draw_w        = $signed({1'b0, ang_q}) - $signed({1'b0, last_angle_q});
  assign cons_inc_w    = (cons_q == 8'hFF) ? cons_q : cons_q + 8'd1;
  assign speed_w       = (act_q == ACT_POLL) && healthy_q && ok_q &&
                         (dt_w >= TIME_W'(poll_period_q));

  always_comb begin
    if (draw_w > HalfS) begin
      dadj_w = draw_w - TurnS;
    end else if (draw_w < NegHalfS) begin
      dadj_w = draw_w + TurnS;
    end else begin
      dadj_w = draw_w;
    end
  end

  // filter update: acc + floor(alpha * diff / 2^16), clamped to the accumulator
  assign acc_ext_w  = {{2{acc_q[ACC_W-1]}}, acc_q};
  assign step_ext_w = {2'b00, p_q[P_W-1:ALPHA_W]};
  assign acc_sum_w  = dneg_q ? acc_ext_w - step_ext_w : acc_ext_w + step_ext_w;

  always_comb begin
    healthy_d     = healthy_q;
    last_angle_d  = last_angle_q;
    turns_d       = turns_q;
    acc_d         = acc_q;
    mag_d         = mag_q;
    err_cnt_d     = err_cnt_q;
    cons_d        = cons_q;
    last_sample_d = last_sample_q;
    last_probe_d  = last_probe_q;
    probe_d       = probe_q;
    taken_d       = taken_q;
    dadj_d        = dadj_q;
    dt_d          = dt_q;
    if (cmd_i.eval) begin
      probe_d = 1'b0;
      taken_d = 1'b0;
      case (action_e'(act_q))
        ACT_POLL: begin
          if (!healthy_q) begin
            if (since_probe_w >= TIME_W'(probe_int_q)) begin
              last_probe_d = now_q;
              probe_d      = 1'b1;
            end
          end else if (dt_w >= TIME_W'(poll_period_q)) begin
            last_sample_d = now_q;
            if (!ok_q) begin
              if (err_cnt_q != '1) err_cnt_d = err_cnt_q + 32'd1;
              cons_d = cons_inc_w;
              if (cons_inc_w >= err_limit_q) healthy_d = 1'b0;
            end else begin
              cons_d       = '0;
              mag_d        = magin_q;
              last_angle_d = ang_q;
              taken_d      = 1'b1;
              dadj_d       = dadj_w;
              dt_d         = (dt_w == '0) ? TIME_W'(1) : dt_w;
              if (draw_w > HalfS) begin
                turns_d = turns_q - TCB'(1);
              end else if (draw_w < NegHalfS) begin
                turns_d = turns_q + TCB'(1);
              end
            end
          end
        end
        ACT_SEED: begin
          if (ok_q) begin
            last_angle_d  = ang_q;
            mag_d         = magin_q;
            acc_d         = '0;
            cons_d        = '0;
            last_sample_d = now_q;
            healthy_d     = 1'b1;
            taken_d       = 1'b1;
          end else begin
            healthy_d = 1'b0;
          end
        end
        ACT_CLEAR: turns_d = '0;
        default:   turns_d = turns_q;
      endcase
    end else if (cmd_i.acc) begin
      if (acc_sum_w > AccMax) begin
        acc_d = AccMax[ACC_W-1:0];
      end else if (acc_sum_w < AccMin) begin
        acc_d = AccMin[ACC_W-1:0];
      end else begin
        acc_d = acc_sum_w[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      healthy_q     <= 1'b0;
      last_angle_q  <= '0;
      turns_q       <= '0;
      acc_q         <= '0;
      mag_q         <= '0;
      err_cnt_q     <= '0;
      cons_q        <= '0;
      last_sample_q <= '0;
      last_probe_q  <= '0;
      probe_q       <= 1'b0;
      taken_q       <= 1'b0;
    end else begin
      healthy_q     <= healthy_d;
      last_angle_q  <= last_angle_d;
      turns_q       <= turns_d;
      acc_q         <= acc_d;
      mag_q         <= mag_d;
      err_cnt_q     <= err_cnt_d;
      cons_q        <= cons_d;
      last_sample_q <= last_sample_d;
      last_probe_q  <= last_probe_d;
      probe_q       <= probe_d;
      taken_q       <= taken_d;
    end
  end

  assign dabs_w = dadj_q[D_W-1] ? D_W'(-dadj_q) : dadj_q;
  assign num_w  = NUM_W'(dabs_w) * NUM_W'(SPEED_SCALE);

  aust_div #(
    .DVD_W (DVD_W),
    .DVS_W (TIME_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.scale),
    .step_i     (cmd_i.div_step),
    .dividend_i (DVD_W'(num_w) << SPEED_FRAC_BITS),
    .divisor_i  (dt_q),
    .quotient_o (quot_w),
    .last_o     (div_last_w)
  );

  assign q_ext_w    = ACC_W'(quot_w);
  assign neg_diff_w = -diff_q;
  assign mul_a_w    = cmd_i.mul_hi ? absd_q[ACC_W-1:HALF_W] : absd_q[HALF_W-1:0];
  assign prod_w     = PROD_W'(mul_a_w) * PROD_W'(alpha_q);

  always_ff @(posedge clk_i) begin
    dadj_q <= dadj_d;
    dt_q   <= dt_d;
    if (cmd_i.inst) inst_q <= dadj_q[D_W-1] ? -$signed(q_ext_w) : $signed(q_ext_w);
    if (cmd_i.diff) diff_q <= {inst_q[ACC_W-1], inst_q} - {acc_q[ACC_W-1], acc_q};
    if (cmd_i.absd) begin
      absd_q <= diff_q[ACC_W] ? neg_diff_w[ACC_W-1:0] : diff_q[ACC_W-1:0];
      dneg_q <= diff_q[ACC_W];
    end
    if (cmd_i.mul_lo) plo_q <= prod_w;
    if (cmd_i.mul_hi) phi_q <= prod_w;
    if (cmd_i.sum) begin
      p_q <= (P_W'(phi_q) << HALF_W) + P_W'(plo_q) +
             (dneg_q ? P_W'({ALPHA_W{1'b1}}) : P_W'(0));
    end
    if (cmd_i.total) total_q <= total_w;
  end

  generate
    if (TCB >= TOT_W) begin : g_tot_trunc
      assign turns45_w = turns_q[TOT_W-1:0];
    end else begin : g_tot_ext
      assign turns45_w = {{(TOT_W-TCB){turns_q[TCB-1]}}, turns_q};
    end
    if (TCB >= OUT32_W) begin : g_tc_trunc
      assign turn32_w = turns_q[OUT32_W-1:0];
    end else begin : g_tc_ext
      assign turn32_w = {{(OUT32_W-TCB){turns_q[TCB-1]}}, turns_q};
    end
  endgenerate

  // turns * 5760 as (turns << 12) + (turns << 10) + (turns << 9) + (turns << 7)
  assign total_w = (turns45_w << 12) + (turns45_w << 10) + (turns45_w << 9) +
                   (turns45_w << 7) + TOT_W'(last_angle_q);

  assign acc_sh_w = acc_q >>> SPEED_FRAC_BITS;

  always_comb begin
    if (!acc_sh_w[ACC_W-1] && (|acc_sh_w[ACC_W-2:OUT32_W-1])) begin
      spd_w = {1'b0, {(OUT32_W-1){1'b1}}};
    end else if (acc_sh_w[ACC_W-1] && !(&acc_sh_w[ACC_W-2:OUT32_W-1])) begin
      spd_w = {1'b1, {(OUT32_W-1){1'b0}}};
    end else begin
      spd_w = acc_sh_w[OUT32_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {3'b000, err_cnt_q, mag_q, spd_w, total_q, turn32_w,
                     last_angle_q, taken_q, probe_q, healthy_q};
    end
  end

  assign out_tvalid_o        = out_valid_q;
  assign out_tdata_o         = out_data_q;
  assign status_o.speed_path = speed_w;
  assign status_o.div_last   = div_last_w;
  assign status_o.out_free   = !out_valid_q || out_tready_i;

endmodule

/* rtl/core/angle_unwrap_speed_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle unwrap and speed tracker
// Unwraps absolute angle readings into turns and total angle, filters speed
// and tracks sensor health with re-probe requests.
// ----------------------------------------------------------------------------
// One request is worked at a time and each gives exactly one result. A poll
// that takes a sample runs the speed path: accept, evaluate, scale the angle
// step, the serial restoring divider (one quotient bit per cycle), filter math
// (instant speed, difference, magnitude, a 24x16 multiplier used twice, sum
// and accumulate), then loading the result register. Every other request goes
// through accept, evaluate, total and result load. A result waits in the
// output register without holding up the next accept; it is only loaded once
// that register is free.
module angle_unwrap_speed_tracker #(
  parameter int TURN_COUNT_BITS = aust_pkg::TURN_COUNT_BITS_DEF,
  parameter int SPEED_FRAC_BITS = aust_pkg::SPEED_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [aust_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [aust_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // now_ms, read_ok, angle_raw, field_magnitude, zero pad
  input  logic [aust_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // action
  input  logic [aust_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // healthy, probe_request, sample_taken, angle_now, turn_count, total_angle,
  // speed, magnitude_now, error_total, zero pad
  output logic [aust_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  import aust_pkg::*;

  cmd_t    cmd;
  status_t status;

  aust_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  aust_dpath #(
    .TURN_COUNT_BITS (TURN_COUNT_BITS),
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_tvalid_o (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .out_tdata_o  (m_axis_tdata)
  );

  a_load_then_eval : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> cmd.eval)
    else $error("accepted request not evaluated next cycle");

  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("new request accepted while one is in work");

  a_out_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten before it was taken");

  a_taken_healthy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[0])
    else $error("sample taken while sensor reported unhealthy");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle unwrap and speed tracker testbench
// Streams angle readings into the tracker and compares each report with a
// cycle-free model of turn counting, speed filtering and sensor health kept
// here. Directed requests cover the seam, range limits, error limit, probing
// and register extremes; random traffic with idle gaps, output stalls and a
// long output hold-off follows.
// ----------------------------------------------------------------------------
module tb;
  import aust_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam longint      ACC_TOP     = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      ACC_BOTTOM  = -ACC_TOP - 1;

  typedef struct packed {
    logic [31:0] error_total;
    logic [7:0]  magnitude_now;
    logic [31:0] speed;
    logic [44:0] total_angle;
    logic [31:0] turn_count;
    logic [12:0] angle_now;
    logic        sample_taken;
    logic        probe_request;
    logic        healthy;
  } report_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [IN_TUSER_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  logic        rx_ready;
  logic        rx_hold;
  int          hold_cycles;
  bit          tx_idle;
  bit          rx_idle;
  int unsigned fail_count;
  int unsigned cycle_count;

  // model state and registers
  logic        trk_healthy;
  logic [12:0] trk_angle;
  logic [31:0] trk_turns;
  longint      trk_acc;
  logic [7:0]  trk_mag;
  logic [31:0] trk_errors;
  logic [7:0]  trk_streak;
  logic [31:0] trk_sample_ms;
  logic [31:0] trk_probe_ms;
  logic [7:0]  reg_poll_period;
  logic [15:0] reg_probe_interval;
  logic [7:0]  reg_error_limit;
  logic [15:0] reg_alpha;

  report_t     pending_reports[$];
  report_t     last_report;
  logic [31:0] stim_ms;
  int unsigned ok_pct;

  assign m_axis_tready = rx_ready & ~rx_hold;

  angle_unwrap_speed_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void update_speed(int d, logic [31:0] dt);
    longint      num;
    longint      inst;
    longint      diff;
    longint      step;
    logic [63:0] mag;
    logic [63:0] quo;
    logic [63:0] prod;
    num = longint'(d) * SPEED_SCALE;
    mag = (num < 0) ? -num : num;
    if (dt == '0) dt = 32'd1;
    quo = (mag << SPEED_FRAC_BITS_DEF) / {32'd0, dt};
    inst = (num < 0) ? -longint'(quo) : longint'(quo);
    diff = inst - trk_acc;
    if (diff >= 0) begin
      mag = diff;
      prod = mag * {48'd0, reg_alpha};
      step = longint'(prod >> ALPHA_W);
    end else begin
      mag = -diff;
      prod = mag * {48'd0, reg_alpha};
      step = -longint'((prod + 64'hFFFF) >> ALPHA_W);
    end
    trk_acc += step;
    if (trk_acc > ACC_TOP) trk_acc = ACC_TOP;
    if (trk_acc < ACC_BOTTOM) trk_acc = ACC_BOTTOM;
  endfunction

  function automatic report_t track_reading(logic [1:0] act, logic [31:0] now, logic ok,
                                            logic [12:0] ang, logic [7:0] mag);
    report_t     rep;
    logic [31:0] elapsed;
    int          d;
    longint      total;
    longint      spd;
    rep = '0;
    case (act)
      ACT_POLL: begin
        if (!trk_healthy) begin
          elapsed = now - trk_probe_ms;
          if (elapsed >= reg_probe_interval) begin
            trk_probe_ms = now;
            rep.probe_request = 1'b1;
          end
        end else begin
          elapsed = now - trk_sample_ms;
          if (elapsed >= reg_poll_period) begin
            trk_sample_ms = now;
            if (!ok) begin
              if (trk_errors != '1) trk_errors++;
              if (trk_streak != '1) trk_streak++;
              if (trk_streak >= reg_error_limit) trk_healthy = 1'b0;
            end else begin
              d = int'(ang) - int'(trk_angle);
              trk_streak = '0;
              trk_mag = mag;
              if (d > HALF_TURN) begin
                d -= TURN_UNITS;
                trk_turns--;
              end else if (d < -HALF_TURN) begin
                d += TURN_UNITS;
                trk_turns++;
              end
              trk_angle = ang;
              update_speed(d, elapsed);
              rep.sample_taken = 1'b1;
            end
          end
        end
      end
      ACT_SEED: begin
        if (ok) begin
          trk_angle = ang;
          trk_mag = mag;
          trk_acc = 0;
          trk_streak = '0;
          trk_sample_ms = now;
          trk_healthy = 1'b1;
          rep.sample_taken = 1'b1;
        end else begin
          trk_healthy = 1'b0;
        end
      end
      ACT_CLEAR: trk_turns = '0;
      default: ;
    endcase
    spd = trk_acc >>> SPEED_FRAC_BITS_DEF;
    if (spd > 64'sd2147483647) spd = 64'sd2147483647;
    if (spd < -64'sd2147483648) spd = -64'sd2147483648;
    total = longint'(signed'(trk_turns)) * TURN_UNITS + longint'(trk_angle);
    rep.healthy       = trk_healthy;
    rep.angle_now     = trk_angle;
    rep.turn_count    = trk_turns;
    rep.total_angle   = total[44:0];
    rep.speed         = spd[31:0];
    rep.magnitude_now = trk_mag;
    rep.error_total   = trk_errors;
    return rep;
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch in %s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  task automatic check_report(report_t got);
    report_t want;
    if (pending_reports.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("report with no request pending: %h", got);
      return;
    end
    want = pending_reports.pop_front();
    compare_field("healthy", 64'(want.healthy), 64'(got.healthy));
    compare_field("probe_request", 64'(want.probe_request), 64'(got.probe_request));
    compare_field("sample_taken", 64'(want.sample_taken), 64'(got.sample_taken));
    compare_field("angle_now", 64'(want.angle_now), 64'(got.angle_now));
    compare_field("turn_count", 64'(want.turn_count), 64'(got.turn_count));
    compare_field("total_angle", 64'(want.total_angle), 64'(got.total_angle));
    compare_field("speed", 64'(want.speed), 64'(got.speed));
    compare_field("magnitude_now", 64'(want.magnitude_now), 64'(got.magnitude_now));
    compare_field("error_total", 64'(want.error_total), 64'(got.error_total));
  endtask

  initial begin : result_sink
    report_t     got;
    int unsigned stall;
    rx_ready = 1'b0;
    wait (rst_ni);
    forever begin
      stall = rx_idle ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        rx_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rx_ready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      got = report_t'(m_axis_tdata[$bits(report_t)-1:0]);
      check_report(got);
    end
  end

  initial begin : sink_hold
    rx_hold = 1'b0;
    forever begin
      wait (hold_cycles > 0);
      @(posedge clk_i);
      rx_hold <= 1'b1;
      repeat (hold_cycles) @(posedge clk_i);
      rx_hold <= 1'b0;
      hold_cycles = 0;
    end
  end

  task automatic send_reading(logic [1:0] act, logic [31:0] now, logic ok,
                              logic [12:0] ang, logic [7:0] mag);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, mag, ang, ok, now};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    last_report = track_reading(act, now, ok, ang, mag);
    pending_reports.push_back(last_report);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_POLL_PERIOD:    reg_poll_period = value[7:0];
      CFG_PROBE_INTERVAL: reg_probe_interval = value;
      CFG_ERROR_LIMIT:    reg_error_limit = value[7:0];
      CFG_SPEED_ALPHA:    reg_alpha = value;
      default: ;
    endcase
  endtask

  task automatic write_all_regs(logic [7:0] period, logic [15:0] interval,
                                logic [7:0] limit, logic [15:0] alpha);
    wait_drained();
    write_reg(CFG_POLL_PERIOD, {8'd0, period});
    write_reg(CFG_PROBE_INTERVAL, interval);
    write_reg(CFG_ERROR_LIMIT, {8'd0, limit});
    write_reg(CFG_SPEED_ALPHA, alpha);
  endtask

  task automatic send_random_reading();
    logic [1:0]  act;
    logic        ok;
    logic [12:0] ang;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (!trk_healthy && last_report.probe_request)
      act = ACT_SEED;
    else if (trk_healthy)
      act = pick < 88 ? ACT_POLL : pick < 93 ? ACT_SEED : pick < 97 ? ACT_CLEAR : ACT_UNUSED;
    else
      act = pick < 80 ? ACT_POLL : pick < 90 ? ACT_SEED : pick < 95 ? ACT_CLEAR : ACT_UNUSED;
    ok = (act == ACT_SEED) ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 99) < ok_pct);

    pick = $urandom_range(0, 99);
    if (pick < 6) stim_ms = $urandom();
    else if (pick < 18) stim_ms += $urandom_range(0, reg_poll_period);
    else if (trk_healthy) stim_ms += reg_poll_period + $urandom_range(0, 40);
    else stim_ms += $urandom_range(0, reg_probe_interval / 2 + 1);

    pick = $urandom_range(0, 99);
    if (pick < 10)
      ang = 13'($urandom_range(0, 8191));
    else if (pick < 25)
      ang = 13'($urandom_range(0, 1) ? $urandom_range(5600, 5759) : $urandom_range(0, 160));
    else
      ang = 13'((int'(trk_angle) % TURN_UNITS + TURN_UNITS + $urandom_range(0, 600) - 300)
                % TURN_UNITS);
    send_reading(act, stim_ms, ok, ang, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_probe_and_seed();
    send_reading(ACT_POLL, 32'd0, 1'b1, 13'h1FFF, 8'hFF);
    send_reading(ACT_POLL, 32'd1000, 1'b1, 13'd0, 8'd0);
    send_reading(ACT_POLL, 32'd1999, 1'b1, 13'd0, 8'd0);
    send_reading(ACT_UNUSED, 32'd2500, 1'b1, 13'd77, 8'd9);
    send_reading(ACT_SEED, 32'd2600, 1'b0, 13'd12, 8'd34);
    send_reading(ACT_SEED, 32'd3000, 1'b1, 13'd5759, 8'hFF);
  endtask

  task automatic test_seam_unwrap();
    send_reading(ACT_POLL, 32'd3003, 1'b1, 13'd10, 8'd1);
    send_reading(ACT_POLL, 32'd3005, 1'b1, 13'd100, 8'd0);
    send_reading(ACT_POLL, 32'd3015, 1'b1, 13'd5700, 8'd200);
    send_reading(ACT_POLL, 32'd3020, 1'b1, 13'h1FFF, 8'd5);
    send_reading(ACT_POLL, 32'd3030, 1'b1, 13'd0, 8'd6);
    send_reading(ACT_POLL, 32'd3040, 1'b1, 13'd2880, 8'd7);
    send_reading(ACT_POLL, 32'd3050, 1'b1, 13'd0, 8'd8);
    send_reading(ACT_CLEAR, 32'd3051, 1'b1, 13'd0, 8'd0);
  endtask

  task automatic test_error_limit();
    send_reading(ACT_POLL, 32'd3060, 1'b0, 13'd0, 8'd0);
    send_reading(ACT_POLL, 32'd3070, 1'b0, 13'd0, 8'd0);
    send_reading(ACT_POLL, 32'd3080, 1'b0, 13'd0, 8'd0);
    send_reading(ACT_POLL, 32'd4100, 1'b1, 13'd0, 8'd0);
    send_reading(ACT_SEED, 32'hFFFF_FFF0, 1'b1, 13'd1234, 8'h5A);
    send_reading(ACT_POLL, 32'h0000_0010, 1'b1, 13'd1300, 8'hA5);
  endtask

  task automatic test_register_extremes();
    write_all_regs(8'd0, 16'd0, 8'd0, 16'hFFFF);
    send_reading(ACT_POLL, 32'h10, 1'b1, 13'd1400, 8'd3);
    send_reading(ACT_POLL, 32'h10, 1'b0, 13'd0, 8'd0);
    send_reading(ACT_POLL, 32'h10, 1'b1, 13'd0, 8'd0);
    send_reading(ACT_SEED, 32'h20, 1'b1, 13'd4000, 8'd44);
    write_all_regs(8'd255, 16'hFFFF, 8'd255, 16'd0);
    send_reading(ACT_POLL, 32'h20 + 32'd254, 1'b1, 13'd4100, 8'd1);
    send_reading(ACT_POLL, 32'h20 + 32'd255, 1'b1, 13'd4100, 8'd2);
    send_reading(ACT_SEED, 32'h200, 1'b0, 13'd0, 8'd0);
    send_reading(ACT_POLL, 32'h300, 1'b1, 13'd0, 8'd0);
    send_reading(ACT_POLL, 32'h10 + 32'd65535, 1'b1, 13'd0, 8'd0);
  endtask

  task automatic test_output_backpressure();
    write_all_regs(8'd2, 16'd50, 8'd3, 16'd30000);
    ok_pct = 95;
    stim_ms = 32'h0001_0000;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_reading(ACT_SEED, stim_ms, 1'b1, 13'd100, 8'd10);
    hold_cycles = 700;
    repeat (30) send_random_reading();
    wait_drained();
    repeat (10) send_random_reading();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_all_regs(8'd0, 16'd0, 8'd1, 16'hFFFF);
        1: write_all_regs(8'd255, 16'hFFFF, 8'd255, 16'd0);
        default: write_all_regs(8'($urandom_range(0, 20)), 16'($urandom_range(0, 300)),
                                8'($urandom_range(0, 6)), 16'($urandom_range(0, 65535)));
      endcase
      ok_pct = $urandom_range(70, 98);
      for (int n = 0; n < 180; n++) begin
        if (n % 40 == 0) begin
          tx_idle = $urandom_range(0, 3) != 0;
          rx_idle = $urandom_range(0, 3) != 0;
        end
        send_random_reading();
      end
    end
  endtask

  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_POLL_PERIOD;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_POLL;
    hold_cycles   = 0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    fail_count    = 0;
    ok_pct        = 90;
    stim_ms       = 32'h100;
    last_report   = '0;

    trk_healthy        = 1'b0;
    trk_angle          = '0;
    trk_turns          = '0;
    trk_acc            = 0;
    trk_mag            = '0;
    trk_errors         = '0;
    trk_streak         = '0;
    trk_sample_ms      = '0;
    trk_probe_ms       = '0;
    reg_poll_period    = POLL_PERIOD_RST;
    reg_probe_interval = PROBE_INTERVAL_RST;
    reg_error_limit    = ERROR_LIMIT_RST;
    reg_alpha          = SPEED_ALPHA_RST;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_probe_and_seed();
    test_seam_unwrap();
    test_error_limit();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && pending_reports.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
